FILE: hw/rtl/mtdm_pkg.sv
// shared types, constants and codes of the move trajectory deviation monitor
// no dependencies; used by every module of the block
package mtdm_pkg;

   localparam int POS_W       = 12;
   localparam int TIME_W      = 16;
   localparam int ERR_W       = 13;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int SETTLE_COUNT = 3;
   localparam int RUN_W        = $clog2(SETTLE_COUNT + 1);

   localparam int PROD_W      = POS_W + TIME_W;
   localparam int DIV_STEPS   = POS_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [STATUS_W-1:0] STATUS_IDLE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MOVING  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SETTLED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DURATION = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOL      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT  = 2'd3;

   localparam logic [POS_W-1:0]  TARGET_RESET   = 12'd0;
   localparam logic [TIME_W-1:0] DURATION_RESET = 16'd0;
   localparam logic [POS_W-1:0]  TOL_RESET      = 12'd50;
   localparam logic [TIME_W-1:0] TIMEOUT_RESET  = 16'd10000;

   typedef struct packed {
      logic [POS_W-1:0]  target_position;
      logic [TIME_W-1:0] duration_ms;
      logic [POS_W-1:0]  tolerance;
      logic [TIME_W-1:0] timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic              start_move;
      logic [TIME_W-1:0] elapsed_ms;
      logic [POS_W-1:0]  position_sample;
      logic              track;
      logic              late;
      logic              near_target;
   } item_type;

endpackage

FILE: hw/rtl/move_trajectory_deviation_monitor.sv
// top level of the move trajectory deviation monitor: registers, front end,
// queue and back end; uses mtdm_pkg, mtdm_front, mtdm_queue, mtdm_back
// path: front stage register, queue, then the back end, which runs the multiply and
// the 12-step serial divider only for a sample tracked against the ideal trajectory;
// the back end takes no new word until the previous result is registered; reset loads register
// defaults, clears move state and all handshakes; words accepted from the first cycle after
module move_trajectory_deviation_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // elapsed_ms [15:0], position_sample [27:16]
   input  logic        req_tuser,  // start_move
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // max_error [12:0], status [14:13]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [mtdm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mtdm_pkg::CSR_DATA_W-1:0]  csr_data
);

   mtdm_pkg::cfg_type  cfg_ff, cfg_in;
   mtdm_pkg::item_type front_item, queue_item;
   logic front_valid, front_ready, queue_valid, queue_ready;
   logic signed [mtdm_pkg::ERR_W-1:0] max_error;
   logic [mtdm_pkg::STATUS_W-1:0]     status;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {1'b0, status, max_error};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mtdm_pkg::CSR_TARGET:   cfg_in.target_position = csr_data[mtdm_pkg::POS_W-1:0];
            mtdm_pkg::CSR_DURATION: cfg_in.duration_ms     = csr_data;
            mtdm_pkg::CSR_TOL:      cfg_in.tolerance       = csr_data[mtdm_pkg::POS_W-1:0];
            mtdm_pkg::CSR_TIMEOUT:  cfg_in.timeout_ms      = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_position <= mtdm_pkg::TARGET_RESET;
         cfg_ff.duration_ms     <= mtdm_pkg::DURATION_RESET;
         cfg_ff.tolerance       <= mtdm_pkg::TOL_RESET;
         cfg_ff.timeout_ms      <= mtdm_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mtdm_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .in_valid           (req_tvalid),
      .in_ready           (req_tready),
      .in_start_move      (req_tuser),
      .in_elapsed_ms      (req_tdata[15:0]),
      .in_position_sample (req_tdata[27:16]),
      .out_valid          (front_valid),
      .out_ready          (front_ready),
      .out_item           (front_item)
   );

   mtdm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   mtdm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (queue_valid),
      .in_ready      (queue_ready),
      .in_item       (queue_item),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_max_error (max_error),
      .out_status    (status)
   );

endmodule

FILE: hw/rtl/mtdm_front.sv
// front end: takes input words, classifies them against the configuration
// and hands them to the queue; uses mtdm_pkg
module mtdm_front (
   input  logic              clock,
   input  logic              reset,
   input  mtdm_pkg::cfg_type cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_start_move,
   input  logic [mtdm_pkg::TIME_W-1:0] in_elapsed_ms,
   input  logic [mtdm_pkg::POS_W-1:0]  in_position_sample,
   output logic              out_valid,
   input  logic              out_ready,
   output mtdm_pkg::item_type out_item
);

   logic               stage_valid_ff, stage_valid_in;
   mtdm_pkg::item_type stage_ff, stage_in;
   logic signed [mtdm_pkg::POS_W:0] diff;
   logic [mtdm_pkg::POS_W-1:0]      distance;

   assign in_ready  = !stage_valid_ff || out_ready;
   assign out_valid = stage_valid_ff;
   assign out_item  = stage_ff;

   always_comb begin
      diff = $signed({1'b0, in_position_sample}) - $signed({1'b0, cfg.target_position});
      distance = diff[mtdm_pkg::POS_W] ? mtdm_pkg::POS_W'(-diff) : mtdm_pkg::POS_W'(diff);
      stage_in.start_move      = in_start_move;
      stage_in.elapsed_ms      = in_elapsed_ms;
      stage_in.position_sample = in_position_sample;
      stage_in.track           = (cfg.duration_ms != '0) &&
                                 (in_elapsed_ms <= cfg.duration_ms);
      stage_in.late            = in_elapsed_ms > cfg.timeout_ms;
      stage_in.near_target     = distance <= cfg.tolerance;
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (in_valid && in_ready) begin
         stage_valid_in = 1'b1;
      end else if (out_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         stage_ff <= stage_in;
      end
   end

endmodule

FILE: hw/rtl/mtdm_queue.sv
// short queue of classified words between front and back end
// uses mtdm_pkg
module mtdm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  mtdm_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output mtdm_pkg::item_type out_item
);

   mtdm_pkg::item_type mem_ff [mtdm_pkg::QUEUE_DEPTH];
   logic [mtdm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [mtdm_pkg::QCNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign in_ready  = count_ff != mtdm_pkg::QCNT_W'(mtdm_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mtdm_pkg::QPTR_W'(mtdm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mtdm_pkg::QPTR_W'(mtdm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

FILE: hw/rtl/mtdm_back.sv
// back end: move state, ideal trajectory through a serial divider, worst
// error tracking, settle and timeout checks, result register; uses mtdm_pkg
module mtdm_back (
   input  logic               clock,
   input  logic               reset,
   input  mtdm_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  mtdm_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [mtdm_pkg::ERR_W-1:0]  out_max_error,
   output logic [mtdm_pkg::STATUS_W-1:0]      out_status
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_DIV  = 5'b00100,
      S_ERR  = 5'b01000,
      S_FIN  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   mtdm_pkg::item_type item_ff, item_in;
   logic [mtdm_pkg::POS_W-1:0]           start_pos_ff, start_pos_in;
   logic signed [mtdm_pkg::ERR_W-1:0]    worst_ff, worst_in;
   logic [mtdm_pkg::RUN_W-1:0]           run_ff, run_in;
   logic [mtdm_pkg::STATUS_W-1:0]        status_ff, status_in;
   logic                                 neg_ff, neg_in;
   logic [mtdm_pkg::TIME_W-1:0]          rem_ff, rem_in;
   logic [mtdm_pkg::POS_W-1:0]           low_ff, low_in;
   logic [mtdm_pkg::POS_W-1:0]           quo_ff, quo_in;
   logic [mtdm_pkg::DIV_CNT_W-1:0]       cnt_ff, cnt_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [mtdm_pkg::ERR_W-1:0]    rsp_err_ff, rsp_err_in;
   logic [mtdm_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;

   logic signed [mtdm_pkg::ERR_W-1:0] span, offs, ideal, err;
   logic [mtdm_pkg::POS_W-1:0]        span_mag;
   logic [mtdm_pkg::PROD_W-1:0]       prod;
   logic [mtdm_pkg::TIME_W:0]         trial, trial_sub;
   logic                              ge;
   logic [mtdm_pkg::ERR_W-1:0]        err_abs, worst_abs;
   logic [mtdm_pkg::RUN_W:0]          run_inc;
   logic                              out_free;

   assign in_ready      = state_ff == S_IDLE;
   assign out_valid     = rsp_valid_ff;
   assign out_max_error = rsp_err_ff;
   assign out_status    = rsp_status_ff;
   assign out_free      = !rsp_valid_ff || out_ready;

   always_comb begin
      span      = $signed({1'b0, cfg.target_position}) - $signed({1'b0, start_pos_ff});
      span_mag  = span[mtdm_pkg::ERR_W-1] ? mtdm_pkg::POS_W'(-span) : mtdm_pkg::POS_W'(span);
      prod      = mtdm_pkg::PROD_W'(span_mag) * mtdm_pkg::PROD_W'(item_ff.elapsed_ms);
      trial     = {rem_ff, low_ff[mtdm_pkg::POS_W-1]};
      ge        = trial >= {1'b0, cfg.duration_ms};
      trial_sub = trial - {1'b0, cfg.duration_ms};
      offs      = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      ideal     = $signed({1'b0, start_pos_ff}) + offs;
      err       = $signed({1'b0, item_ff.position_sample}) - ideal;
      err_abs   = err[mtdm_pkg::ERR_W-1] ? mtdm_pkg::ERR_W'(-err) : mtdm_pkg::ERR_W'(err);
      worst_abs = worst_ff[mtdm_pkg::ERR_W-1] ? mtdm_pkg::ERR_W'(-worst_ff) :
                  mtdm_pkg::ERR_W'(worst_ff);
      run_inc   = {1'b0, run_ff} + 1'b1;
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      start_pos_in  = start_pos_ff;
      worst_in      = worst_ff;
      run_in        = run_ff;
      status_in     = status_ff;
      neg_in        = neg_ff;
      rem_in        = rem_ff;
      low_in        = low_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !out_ready;
      rsp_err_in    = rsp_err_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               item_in = in_item;
               if (in_item.start_move) begin
                  start_pos_in = in_item.position_sample;
                  worst_in     = '0;
                  run_in       = '0;
                  status_in    = mtdm_pkg::STATUS_MOVING;
               end
               if ((in_item.start_move || status_ff == mtdm_pkg::STATUS_MOVING) &&
                   in_item.track) begin
                  state_in = S_MUL;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_MUL: begin
            neg_in   = span[mtdm_pkg::ERR_W-1];
            rem_in   = prod[mtdm_pkg::PROD_W-1:mtdm_pkg::POS_W];
            low_in   = prod[mtdm_pkg::POS_W-1:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = ge ? trial_sub[mtdm_pkg::TIME_W-1:0] : trial[mtdm_pkg::TIME_W-1:0];
            low_in = {low_ff[mtdm_pkg::POS_W-2:0], 1'b0};
            quo_in = {quo_ff[mtdm_pkg::POS_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == mtdm_pkg::DIV_CNT_W'(mtdm_pkg::DIV_STEPS - 1)) begin
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            if (err_abs > worst_abs) begin
               worst_in = err;
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               if (status_ff == mtdm_pkg::STATUS_MOVING) begin
                  status_in = mtdm_pkg::STATUS_MOVING;
                  if (item_ff.near_target) begin
                     run_in = mtdm_pkg::RUN_W'(run_inc);
                     if (run_inc >= (mtdm_pkg::RUN_W + 1)'(mtdm_pkg::SETTLE_COUNT)) begin
                        status_in = mtdm_pkg::STATUS_SETTLED;
                     end
                  end else begin
                     run_in = '0;
                  end
                  if (status_in == mtdm_pkg::STATUS_MOVING && item_ff.late) begin
                     status_in = mtdm_pkg::STATUS_TIMEOUT;
                  end
               end
               rsp_valid_in  = 1'b1;
               rsp_err_in    = worst_ff;
               rsp_status_in = status_in;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_pos_ff <= '0;
         worst_ff     <= '0;
         run_ff       <= '0;
         status_ff    <= mtdm_pkg::STATUS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_pos_ff <= start_pos_in;
         worst_ff     <= worst_in;
         run_ff       <= run_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      neg_ff        <= neg_in;
      rem_ff        <= rem_in;
      low_ff        <= low_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

FILE: hw/rtl/mtdm_checker.sv
// port-level checks of the move trajectory deviation monitor, bound to the top
// level; uses mtdm_pkg
module mtdm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // result held while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed while stalled");

   // no result straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   // idle means no move yet, so no error recorded
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[14:13] == mtdm_pkg::STATUS_IDLE |-> rsp_tdata[12:0] == '0)
      else $error("nonzero error reported while idle");

   // deviation never reaches the most negative code, and the spare top bit stays zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[12:0] != 13'h1000 && !rsp_tdata[15])
      else $error("error field out of range");

endmodule

bind move_trajectory_deviation_monitor mtdm_checker u_mtdm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: sim/testbench.sv
// self-checking testbench of the move trajectory deviation monitor: drives sample words
// and register writes, predicts each result word in a small scoreboard and compares
// depends on mtdm_pkg and move_trajectory_deviation_monitor
module testbench;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int TARGET_WORDS = 1100;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 40;

   typedef struct packed {
      logic [mtdm_pkg::STATUS_W-1:0] status;
      logic [mtdm_pkg::ERR_W-1:0]    max_error;
   } result_type;

   class move_monitor_scoreboard;
      logic [mtdm_pkg::POS_W-1:0]    target;
      logic [mtdm_pkg::TIME_W-1:0]   duration;
      logic [mtdm_pkg::POS_W-1:0]    tol;
      logic [mtdm_pkg::TIME_W-1:0]   timeout;
      int                            start_pos;
      int                            worst;
      int                            run;
      logic [mtdm_pkg::STATUS_W-1:0] status;
      result_type                    expected_q[$];
      int                            errors;
      int                            moves;
      int                            settled;
      int                            timed_out;

      function new();
         target    = mtdm_pkg::TARGET_RESET;
         duration  = mtdm_pkg::DURATION_RESET;
         tol       = mtdm_pkg::TOL_RESET;
         timeout   = mtdm_pkg::TIMEOUT_RESET;
         start_pos = 0;
         worst     = 0;
         run       = 0;
         status    = mtdm_pkg::STATUS_IDLE;
         errors    = 0;
         moves     = 0;
         settled   = 0;
         timed_out = 0;
      endfunction

      function int magnitude(int v);
         return (v < 0) ? -v : v;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void write_reg(logic [mtdm_pkg::CSR_INDEX_W-1:0] idx,
                              logic [mtdm_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            mtdm_pkg::CSR_TARGET:   target   = value[mtdm_pkg::POS_W-1:0];
            mtdm_pkg::CSR_DURATION: duration = value[mtdm_pkg::TIME_W-1:0];
            mtdm_pkg::CSR_TOL:      tol      = value[mtdm_pkg::POS_W-1:0];
            mtdm_pkg::CSR_TIMEOUT:  timeout  = value[mtdm_pkg::TIME_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_word(logic start, logic [mtdm_pkg::TIME_W-1:0] elapsed,
                              logic [mtdm_pkg::POS_W-1:0] pos);
         int         ideal;
         int         err;
         int         distance;
         result_type r;
         if (start) begin
            start_pos = int'(pos);
            worst     = 0;
            run       = 0;
            status    = mtdm_pkg::STATUS_MOVING;
            moves++;
         end
         if (status == mtdm_pkg::STATUS_MOVING) begin
            if (duration != 0 && elapsed <= duration) begin
               ideal = start_pos +
                  ((int'(target) - start_pos) * int'(elapsed)) / int'(duration);
               err = int'(pos) - ideal;
               if (magnitude(err) > magnitude(worst)) worst = err;
            end
            distance = magnitude(int'(pos) - int'(target));
            if (distance <= int'(tol)) begin
               run++;
               if (run >= mtdm_pkg::SETTLE_COUNT) begin
                  status = mtdm_pkg::STATUS_SETTLED;
                  settled++;
               end
            end else begin
               run = 0;
            end
            if (status == mtdm_pkg::STATUS_MOVING && elapsed > timeout) begin
               status = mtdm_pkg::STATUS_TIMEOUT;
               timed_out++;
            end
         end
         r.status    = status;
         r.max_error = worst[mtdm_pkg::ERR_W-1:0];
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [15:0] word);
         result_type got;
         result_type want;
         got = word[mtdm_pkg::STATUS_W+mtdm_pkg::ERR_W-1:0];
         if (expected_q.size() == 0) begin
            $display("%0t: result word 0x%h arrived with none expected", $time, word);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.max_error !== want.max_error) begin
            $display("%0t: max_error expected %0d, actual %0d", $time,
                     $signed(want.max_error), $signed(got.max_error));
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [31:0]                      req_tdata  = '0;  // elapsed_ms [15:0], position_sample [27:16]
   logic                             req_tuser  = 1'b0;  // start_move
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [15:0]                      rsp_tdata;  // max_error [12:0], status [14:13]
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [mtdm_pkg::CSR_INDEX_W-1:0] csr_index  = mtdm_pkg::CSR_TARGET;
   logic [mtdm_pkg::CSR_DATA_W-1:0]  csr_data   = '0;

   move_monitor_scoreboard sb = new();

   int          cycle_count   = 0;
   int          words_sent    = 0;
   int          csr_writes    = 0;
   int          burst_left    = 0;
   bit          gaps_on       = 1'b1;
   int          hold_request  = 0;
   int          hold_left     = 0;
   int          stall_mode    = 0;
   int          mode_left     = 0;
   logic [15:0] stall_pattern = 16'hffff;
   int          cur_target    = 0;
   int          cur_dur       = 0;
   int          cur_tol       = 50;
   int          cur_timeout   = 10000;

   move_trajectory_deviation_monitor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, sb.pending());
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // receiver: long hold-off on request, otherwise changing stall modes
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         if (mode_left == 0) begin
            stall_mode    = $urandom_range(0, 2);
            mode_left     = $urandom_range(20, 120);
            stall_pattern = 16'($urandom) | 16'h0001;
         end
         mode_left--;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: begin
               rsp_tready    <= stall_pattern[0];
               stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
            end
         endcase
      end
   end

   task automatic send_word(input logic start, input logic [15:0] elapsed,
                            input logic [11:0] pos);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (gaps_on) begin
            gap = $urandom_range(1, 10);
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= start;
      req_tdata  <= {4'b0, pos, elapsed};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(start, elapsed, pos);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [mtdm_pkg::CSR_INDEX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[mtdm_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, value[mtdm_pkg::CSR_DATA_W-1:0]);
      csr_writes++;
      @(negedge clock);
   endtask

   task automatic set_config(input int t, input int d, input int tl, input int to);
      drain_results();
      write_csr(mtdm_pkg::CSR_TARGET, t);
      write_csr(mtdm_pkg::CSR_DURATION, d);
      write_csr(mtdm_pkg::CSR_TOL, tl);
      write_csr(mtdm_pkg::CSR_TIMEOUT, to);
      csr_valid  <= 1'b0;
      cur_target  = t;
      cur_dur     = d;
      cur_tol     = tl;
      cur_timeout = to;
   endtask

   task automatic send_noise();
      int count;
      count = $urandom_range(1, 6);
      repeat (count)
         send_word($urandom_range(0, 9) == 0, 16'($urandom_range(0, 65535)),
                   12'($urandom_range(0, 4095)));
   endtask

   // start word then samples near the ideal line, often closing in on the target
   task automatic run_move();
      int n;
      int p0;
      int el;
      int step_max;
      int ideal;
      int pos;
      int w;
      int r;
      n = $urandom_range(4, 16);
      case ($urandom_range(0, 5))
         0: p0 = 0;
         1: p0 = 4095;
         default: p0 = $urandom_range(0, 4095);
      endcase
      el = $urandom_range(0, 3);
      send_word(1'b1, el[15:0], p0[11:0]);
      step_max = (cur_dur == 0) ? 25 : cur_dur / n + 1;
      w = (cur_tol < 30) ? cur_tol + 2 : 30;
      for (int k = 1; k < n; k++) begin
         if ($urandom_range(0, 9) == 0) el += $urandom_range(0, 3 * step_max);
         else el += $urandom_range(0, step_max);
         if (el > 65535) el = 65535;
         if (cur_dur != 0 && el <= cur_dur) ideal = p0 + ((cur_target - p0) * el) / cur_dur;
         else ideal = cur_target;
         if (k >= n - 4 && $urandom_range(0, 2) != 0) begin
            r   = $urandom_range(0, 2 * w);
            pos = cur_target + r - w;
         end else begin
            r   = $urandom_range(0, 80);
            pos = ideal + r - 40;
         end
         if (pos < 0) pos = 0;
         if (pos > 4095) pos = 4095;
         send_word(1'b0, el[15:0], pos[11:0]);
      end
   endtask

   initial begin
      int t;
      int d;
      int tl;
      int to;
      int phase;
      int n_moves;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // idle without a start word holds everything
      send_word(1'b0, 16'hffff, 12'hfff);
      // full-scale rising move, zero tolerance, settles after the expected duration
      set_config(4095, 100, 0, 65535);
      send_word(1'b1, 16'd0, 12'd0);
      send_word(1'b0, 16'd50, 12'd4095);
      send_word(1'b0, 16'd50, 12'd0);
      send_word(1'b0, 16'd100, 12'd4095);
      send_word(1'b0, 16'd150, 12'd4095);
      send_word(1'b0, 16'd150, 12'd4095);
      send_word(1'b0, 16'd200, 12'd0);
      // start word times out at once, largest error, restart in timed-out state
      set_config(0, 65535, 4095, 0);
      send_word(1'b1, 16'hffff, 12'd4095);
      send_word(1'b1, 16'd1, 12'd4095);
      // falling move: truncation toward zero, equal magnitude keeps the first
      set_config(0, 7, 0, 65535);
      send_word(1'b1, 16'd0, 12'd100);
      send_word(1'b0, 16'd3, 12'd58);
      send_word(1'b0, 16'd0, 12'd131);
      send_word(1'b0, 16'd0, 12'd69);
      send_word(1'b0, 16'd8, 12'd4095);
      // zero duration; settling on the sample past the timeout wins
      set_config(2000, 0, 10, 5);
      send_word(1'b1, 16'd0, 12'd2000);
      send_word(1'b0, 16'd3, 12'd2005);
      send_word(1'b0, 16'd9, 12'd1990);
      send_word(1'b0, 16'd9, 12'd4095);

      phase = 0;
      while (words_sent < TARGET_WORDS) begin
         case ($urandom_range(0, 3))
            0: t = 0;
            1: t = 4095;
            default: t = $urandom_range(0, 4095);
         endcase
         case ($urandom_range(0, 5))
            0: d = 0;
            1: d = 65535;
            2: d = 1;
            default: d = $urandom_range(4, 200);
         endcase
         case ($urandom_range(0, 4))
            0: tl = 0;
            1: tl = 4095;
            default: tl = $urandom_range(0, 100);
         endcase
         case ($urandom_range(0, 4))
            0: to = 0;
            1: to = 65535;
            2: to = $urandom_range(0, 65535);
            default: to = (d + $urandom_range(0, 60) > 65535) ? 65535 : d + $urandom_range(0, 60);
         endcase
         set_config(t, d, tl, to);
         gaps_on = ($urandom_range(0, 3) != 0);
         if (phase == 2) hold_request = HOLD_CYCLES;
         n_moves = $urandom_range(3, 8);
         for (int m = 0; m < n_moves; m++) begin
            if (phase == 5 && m == 1) drain_results();
            if ($urandom_range(0, 6) == 0) send_noise();
            else run_move();
         end
         phase++;
      end
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d sample words under %0d register writes in %0d cycles",
               words_sent, csr_writes, cycle_count);
      $display("moves started %0d, settled %0d, timed out %0d, mismatches %0d",
               sb.moves, sb.settled, sb.timed_out, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

FILE: files.f
hw/rtl/mtdm_pkg.sv
hw/rtl/mtdm_front.sv
hw/rtl/mtdm_queue.sv
hw/rtl/mtdm_back.sv
hw/rtl/move_trajectory_deviation_monitor.sv
hw/rtl/mtdm_checker.sv
sim/testbench.sv
